// ----- design/rtpnack_pkg.sv -----
// rtpnack_pkg: types and constants of the NACK retransmit selector.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package rtpnack_pkg;

  // Request opcodes (func field)
  localparam logic [1:0] FUNC_STORE  = 2'd0;
  localparam logic [1:0] FUNC_NACK   = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_NACK_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MTU_BYTES   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_RTT = 2'd2;

  localparam logic        NACK_ENABLE_RST = 1'b1;
  localparam logic [15:0] MTU_BYTES_RST   = 16'd1500;
  localparam logic [15:0] DEFAULT_RTT_RST = 16'd100;

  // NACK walk: packet id plus one id per lost mask bit
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned WALK_W  = 5;
  localparam logic [WALK_W-1:0] MAX_REQUESTED = 5'd17;

  // RTT in ms = raw 16.16 seconds * 1000 >> 16
  localparam int unsigned SCALE_W = 10;
  localparam logic [SCALE_W-1:0] MS_PER_S = 10'd1000;
  localparam int unsigned PROD_W  = 32 + SCALE_W;
  localparam logic [7:0]  COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] seq_number;
    logic [15:0] lost_mask;
    logic [15:0] packet_bytes;
    logic [31:0] now_ms;
    logic [31:0] last_report_stamp;
    logic [31:0] report_delay;
    logic [31:0] compact_now;
  } req_item_t;

  typedef struct packed {
    logic        resend_valid;
    logic [15:0] resend_seq;
    logic [7:0]  resend_count;
    logic [15:0] current_rtt_ms;
    logic        last;
  } res_item_t;

  // One slot of the retransmit table
  typedef struct packed {
    logic        valid;
    logic [15:0] seq;
    logic [31:0] resent_ms;
    logic [7:0]  resend_count;
  } entry_t;

endpackage

`default_nettype wire

// ----- design/rtpnack_req_if.sv -----
// rtpnack_req_if: request channel (valid/ready plus request item).
// Depends on rtpnack_pkg.
`default_nettype none

interface rtpnack_req_if
  import rtpnack_pkg::*;
  ();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/rtpnack_res_if.sv -----
// rtpnack_res_if: result channel (valid/ready plus result item).
// Depends on rtpnack_pkg.
`default_nettype none

interface rtpnack_res_if
  import rtpnack_pkg::*;
  ();
  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/rtpnack_table.sv -----
// rtpnack_table: direct-mapped retransmit table, one write and one
// registered read port. Depends on rtpnack_pkg.
`default_nettype none

module rtpnack_table
  import rtpnack_pkg::*;
#(
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire entry_t                   wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/rtp_nack_retransmit_selector_top.sv -----
// rtp_nack_retransmit_selector_top: sender-side NACK responder.
// Depends on rtpnack_pkg, rtpnack_req_if, rtpnack_res_if, rtpnack_table.
//
// Channel   Dir  Carries
// --------  ---  ------------------------------------------------------
// request   in   req_item_t: store / NACK / receiver report request
// result    out  res_item_t: one retransmit (or empty) result, last flag
// cfg_*     in   register write: nack_enable, mtu_bytes, default_rtt_ms
//
// After reset the table is swept clear, one slot a cycle, with
// request.ready low (config writes still taken).
// Store: table write, then the result. Report: sum/compare, multiply, saturate.
// NACK: each looked-up id is read, then checked; a clear mask bit is
// skipped. The single table read port allows one lookup per id.
// A request is taken while the previous result still sits in the output
// register; a stalled result output holds the walk at the next hit, and
// holds the final result.
// TABLE_DEPTH must be a power of two (slot = low bits of the sequence).
`default_nettype none

module rtp_nack_retransmit_selector_top
  import rtpnack_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 2048
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  rtpnack_req_if.sink                 request,
  rtpnack_res_if.source               result,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_STORE,
    S_LOOK,
    S_CHK,
    S_RPT_SUM,
    S_RPT_MUL,
    S_RPT_SAT,
    S_FIN
  } state_t;

  state_t state;

  // configuration
  logic        nack_enable;
  logic [15:0] mtu_bytes;
  logic [15:0] default_rtt_ms;

  // held request and walk state
  req_item_t         item;
  logic [WALK_W-1:0] walk;
  logic [15:0]       rtt_ms;
  logic [15:0]       rtt_eff;
  logic [IDX_W-1:0]  clr_addr;

  // a hit is held back until we know whether it is the last one
  logic        held_v;
  logic [15:0] held_seq;
  logic [7:0]  held_count;

  // report datapath
  logic [31:0]       raw;
  logic [PROD_W-1:0] prod;

  // output register
  logic      res_valid;
  res_item_t res_data;
  logic      res_load;

  // table port
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  entry_t           tbl_wdata;
  logic             tbl_re;
  entry_t           tbl_rdata;

  // combinational helpers
  logic [15:0]       cur_seq;
  logic [3:0]        bit_sel;
  logic              walk_done;
  logic              skip;
  logic              match;
  logic [31:0]       age;
  logic              recent;
  logic              hit;
  logic [7:0]        new_count;
  logic              slot_free;
  logic              chk_go;
  logic              store_ok;
  logic [31:0]       rpt_sum;
  logic              rpt_ok;
  logic [PROD_W-17:0] ms_full;
  logic [15:0]       ms_sat;

  assign cur_seq   = item.seq_number + 16'(walk);
  assign bit_sel   = 4'(walk - WALK_W'(1));
  assign walk_done = (walk == MAX_REQUESTED);
  assign skip      = (walk != '0) && !item.lost_mask[bit_sel];

  assign match     = tbl_rdata.valid && (tbl_rdata.seq == cur_seq);
  assign age       = item.now_ms - tbl_rdata.resent_ms;
  assign recent    = (tbl_rdata.resend_count != '0) && (age <= {16'd0, rtt_eff});
  assign hit       = match && !recent;
  assign new_count = (tbl_rdata.resend_count == COUNT_MAX) ? COUNT_MAX
                                                           : tbl_rdata.resend_count + 8'd1;

  assign slot_free = !res_valid || result.ready;
  assign chk_go    = hit && (!held_v || slot_free);
  assign store_ok  = nack_enable && (item.packet_bytes <= mtu_bytes);

  // output register loads on an earlier held hit, or on the final result
  assign res_load  = ((state == S_CHK) && chk_go && held_v) ||
                     ((state == S_FIN) && slot_free);

  assign rpt_sum   = item.report_delay + item.last_report_stamp;
  assign rpt_ok    = (item.last_report_stamp != '0) && (item.report_delay != '0) &&
                     (item.compact_now > rpt_sum);
  assign ms_full   = prod[PROD_W-1:16];
  assign ms_sat    = (|ms_full[PROD_W-17:16]) ? 16'hFFFF : ms_full[15:0];

  // table access sequencing
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = cur_seq[IDX_W-1:0];
    tbl_wdata = '0;
    priority if (state == S_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_addr;
    end else if (state == S_STORE) begin
      tbl_we    = store_ok;
      tbl_waddr = item.seq_number[IDX_W-1:0];
      tbl_wdata = '{valid: 1'b1, seq: item.seq_number, resent_ms: '0, resend_count: '0};
    end else if (state == S_CHK) begin
      tbl_we    = chk_go;
      tbl_wdata = '{valid: 1'b1, seq: cur_seq, resent_ms: item.now_ms,
                    resend_count: new_count};
    end else begin
      tbl_we    = 1'b0;
    end
  end

  assign tbl_re = (state == S_LOOK) && !walk_done && !skip;

  rtpnack_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (cur_seq[IDX_W-1:0]),
    .rdata (tbl_rdata)
  );

  assign request.ready = (state == S_IDLE);
  assign result.valid  = res_valid;
  assign result.data   = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      res_valid      <= 1'b0;
      held_v         <= 1'b0;
      rtt_ms         <= '0;
      walk           <= '0;
      nack_enable    <= NACK_ENABLE_RST;
      mtu_bytes      <= MTU_BYTES_RST;
      default_rtt_ms <= DEFAULT_RTT_RST;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_NACK_ENABLE: nack_enable    <= cfg_data[0];
          REG_MTU_BYTES:   mtu_bytes      <= cfg_data;
          REG_DEFAULT_RTT: default_rtt_ms <= cfg_data;
          default: ;
        endcase
      end

      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == {IDX_W{1'b1}}) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (request.valid) begin
            item <= request.data;
            walk <= '0;
            rtt_eff <= (rtt_ms != '0) ? rtt_ms : default_rtt_ms;
            unique case (request.data.func)
              FUNC_STORE:  state <= S_STORE;
              FUNC_NACK:   state <= nack_enable ? S_LOOK : S_FIN;
              FUNC_REPORT: state <= S_RPT_SUM;
              FUNC_NOP:    state <= S_FIN;
            endcase
          end
        end

        S_STORE: state <= S_FIN;

        S_LOOK: begin
          priority if (walk_done) begin
            state <= S_FIN;
          end else if (skip) begin
            walk <= walk + WALK_W'(1);
          end else begin
            state <= S_CHK;
          end
        end

        S_CHK: begin
          if (!hit) begin
            walk  <= walk + WALK_W'(1);
            state <= S_LOOK;
          end else if (chk_go) begin
            if (held_v) begin
              res_data  <= '{resend_valid: 1'b1, resend_seq: held_seq,
                             resend_count: held_count, current_rtt_ms: rtt_ms,
                             last: 1'b0};
            end
            held_v     <= 1'b1;
            held_seq   <= cur_seq;
            held_count <= new_count;
            walk       <= walk + WALK_W'(1);
            state      <= S_LOOK;
          end
        end

        S_RPT_SUM: begin
          raw   <= rpt_ok ? (item.compact_now - rpt_sum) : '0;
          state <= S_RPT_MUL;
        end

        S_RPT_MUL: begin
          prod  <= PROD_W'(raw) * PROD_W'(MS_PER_S);
          state <= S_RPT_SAT;
        end

        S_RPT_SAT: begin
          rtt_ms <= ms_sat;
          state  <= S_FIN;
        end

        S_FIN: begin
          if (slot_free) begin
            if (held_v) begin
              res_data <= '{resend_valid: 1'b1, resend_seq: held_seq,
                            resend_count: held_count, current_rtt_ms: rtt_ms,
                            last: 1'b1};
            end else begin
              res_data <= '{resend_valid: 1'b0, resend_seq: '0, resend_count: '0,
                            current_rtt_ms: rtt_ms, last: 1'b1};
            end
            held_v <= 1'b0;
            state  <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no request may be taken before the clearing sweep has finished
  a_ready_after_clear: assert property (@(posedge clk) disable iff (rst)
    request.ready |-> !(state == S_CLEAR))
    else $error("request taken during table clear");

  // table is written only by clear, store and a NACK hit
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (state == S_CLEAR || state == S_STORE || state == S_CHK))
    else $error("unexpected table write");

  // a held hit exists only inside a NACK walk
  a_held_in_walk: assert property (@(posedge clk) disable iff (rst)
    held_v |-> (state == S_LOOK || state == S_CHK || state == S_FIN))
    else $error("held result outside NACK walk");

  // the walk never runs past the last requested id
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (walk < MAX_REQUESTED))
    else $error("NACK walk out of range");

  // a result going out on a stalled output would overwrite one
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |=> res_valid && $stable(res_data))
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ----- dv/rtp_nack_retransmit_selector_top_tb.sv -----
`timescale 1ns / 100ps
// rtp_nack_retransmit_selector_top_tb: self-checking bench for the NACK retransmit selector.
// Uses rtpnack_pkg, rtpnack_req_if, rtpnack_res_if and the top level of the block.
// A bench-side table and RTT shadow predict every result, and each result is compared in order.

module rtp_nack_retransmit_selector_top_tb;
  import rtpnack_pkg::*;

  localparam int unsigned SLOTS         = 2048;
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned PRINT_CAP     = 100;
  localparam int unsigned IDLE_PERCENT  = 29;
  localparam logic [41:0] MS_PER_SECOND = 42'd1000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rtpnack_req_if req_ch ();
  rtpnack_res_if res_ch ();

  rtp_nack_retransmit_selector_top #(
    .TABLE_DEPTH (SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .request   (req_ch),
    .result    (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Bench copy of the retransmit table, the held RTT and the registers
  // ---------------------------------------------------------------------------
  logic        slot_live      [SLOTS];
  logic [15:0] slot_seq       [SLOTS];
  logic [31:0] slot_resent_at [SLOTS];
  logic [7:0]  slot_resends   [SLOTS];
  logic [15:0] held_rtt = 16'd0;

  logic        cfg_enable      = NACK_ENABLE_RST;
  logic [15:0] cfg_mtu         = MTU_BYTES_RST;
  logic [15:0] cfg_default_rtt = DEFAULT_RTT_RST;

  res_item_t   pending_answers[$];   // results owed by the block, oldest first
  int unsigned failures = 0;
  int unsigned cycles   = 0;
  logic        steady_flow = 1'b0;   // 1: neither side idles
  logic [31:0] clock_ms;             // sender's notion of now, in ms
  res_item_t   oldest;

  // Works out every result one request causes and queues them.
  function automatic void answer_request(input req_item_t r);
    res_item_t   hits[$];
    res_item_t   one;
    logic [15:0] id;
    int unsigned slot;
    logic [31:0] window;
    logic [31:0] stamp_sum;
    logic [31:0] raw;
    logic [41:0] scaled;
    case (r.func)
      FUNC_STORE: begin
        if (cfg_enable && r.packet_bytes <= cfg_mtu) begin
          slot = r.seq_number % SLOTS;
          slot_live[slot]      = 1'b1;
          slot_seq[slot]       = r.seq_number;
          slot_resent_at[slot] = '0;
          slot_resends[slot]   = '0;
        end
      end
      FUNC_NACK: begin
        if (cfg_enable) begin
          window = (held_rtt != 16'd0) ? {16'd0, held_rtt} : {16'd0, cfg_default_rtt};
          // id 0 is the PID itself, id i the PID plus i when mask bit i-1 is set
          for (int i = 0; i < MAX_REQUESTED; i++) begin
            if (i > 0 && !r.lost_mask[i-1]) continue;
            id   = r.seq_number + 16'(i);
            slot = id % SLOTS;
            if (!slot_live[slot] || slot_seq[slot] != id) continue;
            // resent recently: hold off until a full RTT has passed
            if (slot_resends[slot] != 8'd0 && (r.now_ms - slot_resent_at[slot]) <= window)
              continue;
            slot_resent_at[slot] = r.now_ms;
            if (slot_resends[slot] != COUNT_MAX) slot_resends[slot]++;
            one.resend_valid   = 1'b1;
            one.resend_seq     = id;
            one.resend_count   = slot_resends[slot];
            one.current_rtt_ms = held_rtt;
            one.last           = 1'b0;
            hits.push_back(one);
          end
        end
      end
      FUNC_REPORT: begin
        // LSR/DLSR round trip; sum of the two taken modulo 2^32
        stamp_sum = r.last_report_stamp + r.report_delay;
        raw = '0;
        if (r.last_report_stamp != '0 && r.report_delay != '0 && r.compact_now > stamp_sum)
          raw = r.compact_now - stamp_sum;
        scaled   = (42'(raw) * MS_PER_SECOND) >> 16;
        held_rtt = (scaled > 42'hFFFF) ? 16'hFFFF : scaled[15:0];
      end
      default: ;
    endcase
    if (hits.size() == 0) begin
      one = '0;
      one.current_rtt_ms = held_rtt;
      one.last = 1'b1;
      hits.push_back(one);
    end else begin
      hits[hits.size()-1].last = 1'b1;
    end
    foreach (hits[k]) pending_answers.push_back(hits[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // Failure reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic note_failure(input string msg);
    if (failures < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    failures++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) note_failure($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  // Sampled at the edge, so both sides' nonblocking updates are still pending.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_answers.size() == 0) begin
        note_failure($sformatf("unexpected result seq %0h", res_ch.data.resend_seq));
      end else begin
        oldest = pending_answers.pop_front();
        compare_field("resend_valid", 32'(res_ch.data.resend_valid),
                      32'(oldest.resend_valid));
        compare_field("resend_seq", 32'(res_ch.data.resend_seq),
                      32'(oldest.resend_seq));
        compare_field("resend_count", 32'(res_ch.data.resend_count),
                      32'(oldest.resend_count));
        compare_field("current_rtt_ms", 32'(res_ch.data.current_rtt_ms),
                      32'(oldest.current_rtt_ms));
        compare_field("last", 32'(res_ch.data.last), 32'(oldest.last));
      end
    end
  end

  // Result side back-pressure, held low through reset
  always @(posedge clk) begin
    res_ch.ready <= !rst && (steady_flow || ($urandom_range(99) >= IDLE_PERCENT));
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // valid is left high after a request is taken: the next call either lowers
  // it for a gap or presents the next request in the same step.
  task automatic issue_request(input req_item_t item);
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    answer_request(item);
  endtask

  // Lowers valid and waits for every owed result; ends each test and phase.
  task automatic drain_answers();
    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic program_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_NACK_ENABLE: cfg_enable      = value[0];
      REG_MTU_BYTES:   cfg_mtu         = value;
      REG_DEFAULT_RTT: cfg_default_rtt = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_all(input logic enable, input logic [15:0] mtu,
                             input logic [15:0] rtt);
    program_register(REG_NACK_ENABLE, {15'd0, enable});
    program_register(REG_MTU_BYTES, mtu);
    program_register(REG_DEFAULT_RTT, rtt);
  endtask

  // Every field random; callers overwrite the ones that matter.
  function automatic req_item_t noisy_request(input logic [1:0] func);
    req_item_t item;
    item.func              = func;
    item.seq_number        = 16'($urandom);
    item.lost_mask         = 16'($urandom);
    item.packet_bytes      = 16'($urandom);
    item.now_ms            = $urandom;
    item.last_report_stamp = $urandom;
    item.report_delay      = $urandom;
    item.compact_now       = $urandom;
    return item;
  endfunction

  task automatic send_store(input logic [15:0] seq, input logic [15:0] bytes);
    req_item_t item;
    item = noisy_request(FUNC_STORE);
    item.seq_number   = seq;
    item.packet_bytes = bytes;
    issue_request(item);
  endtask

  task automatic send_nack(input logic [15:0] pid, input logic [15:0] mask,
                           input logic [31:0] now);
    req_item_t item;
    item = noisy_request(FUNC_NACK);
    item.seq_number = pid;
    item.lost_mask  = mask;
    item.now_ms     = now;
    issue_request(item);
  endtask

  task automatic send_report(input logic [31:0] lsr, input logic [31:0] dlsr,
                             input logic [31:0] compact);
    req_item_t item;
    item = noisy_request(FUNC_REPORT);
    item.last_report_stamp = lsr;
    item.report_delay      = dlsr;
    item.compact_now       = compact;
    issue_request(item);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset registers: MTU edge, sequence wrap in the walk, window edge, eviction.
  task automatic test_store_and_nack();
    logic [31:0] t0;
    t0 = clock_ms;
    send_store(16'h0000, 16'd1500);      // exactly the MTU: kept
    send_store(16'h0001, 16'd1501);      // one over: dropped
    send_store(16'hFFFF, 16'h0000);
    send_store(16'h0002, 16'd64);
    send_nack(16'hFFFF, 16'hFFFF, t0);   // walk wraps to 0..15
    send_nack(16'hFFFF, 16'h0005, t0 + 32'd100);   // all inside the default RTT
    send_nack(16'h0000, 16'h0002, t0 + 32'd101);   // just outside
    send_store(16'h0800, 16'd200);       // same slot as seq 0
    send_nack(16'h0000, 16'h0000, t0 + 32'd500);   // evicted: no hit
    send_nack(16'h0800, 16'h8000, t0 + 32'd500);
    issue_request(noisy_request(FUNC_NOP));
    drain_answers();
    clock_ms = t0 + 32'd1000;
  endtask

  // Report validity rules, sum wrap, saturation, and the widest window.
  task automatic test_rtt_reports();
    logic [31:0] t0;
    send_report(32'h0000_0000, 32'h0001_0000, 32'h8000_0000);   // no LSR
    send_report(32'h1000_0000, 32'h0000_0000, 32'h8000_0000);   // no DLSR
    send_report(32'h1000_0000, 32'h0001_0000, 32'h1001_0000);   // not greater
    send_report(32'h1000_0000, 32'h0001_0000, 32'h1001_3333);
    send_report(32'hFFFF_0000, 32'h0002_0000, 32'h0002_0000);   // LSR + DLSR wraps
    send_report(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);   // saturates
    t0 = clock_ms;
    send_store(16'h1234, 16'd1000);
    send_nack(16'h1234, 16'h0000, t0);
    send_nack(16'h1234, 16'h0000, t0 + 32'd65535);   // on the window edge
    send_nack(16'h1234, 16'h0000, t0 + 32'd65536);
    send_report(32'h0000_0000, 32'h0000_0001, 32'h0000_0001);   // back to no RTT
    drain_answers();
    clock_ms = t0 + 32'd70000;
  endtask

  // Register extremes, NACK handling switched off, reports taken regardless.
  task automatic test_register_extremes();
    logic [31:0] t0;
    t0 = clock_ms;
    program_all(1'b1, 16'd0, 16'd1);
    send_store(16'h0005, 16'd0);
    send_store(16'h0006, 16'd1);
    send_nack(16'h0005, 16'h0001, t0);
    send_nack(16'h0005, 16'h0001, t0 + 32'd1);
    send_nack(16'h0005, 16'h0001, t0 + 32'd3);
    drain_answers();
    program_all(1'b0, 16'hFFFF, 16'hFFFF);
    send_store(16'h0007, 16'hFFFF);
    send_nack(16'h0005, 16'hFFFF, t0 + 32'd100);
    send_report(32'h2000_0000, 32'h0000_8000, 32'h2000_9000);
    drain_answers();
    program_register(REG_NACK_ENABLE, 16'd1);
    send_store(16'h0007, 16'hFFFF);
    send_nack(16'h0005, 16'h0003, t0 + 32'd110);
    send_report(32'h0000_0000, 32'h0000_0001, 32'h0000_0001);
    drain_answers();
    clock_ms = t0 + 32'd1000;
  endtask

  // One packet NACKed until its resend count pins at the top, with random
  // neighbours hit by the mask. Its NACKs open with a stretch of no idling.
  task automatic test_resend_saturation();
    logic [15:0] hot;
    int unsigned hot_slot;
    int unsigned extra;
    int unsigned sent;
    logic [31:0] window;
    hot      = 16'($urandom);
    hot_slot = hot % SLOTS;
    program_all(1'b1, 16'd1500, 16'($urandom_range(2, 50)));
    send_store(hot, 16'($urandom_range(0, 1500)));
    for (int k = 1; k < MAX_REQUESTED; k++)
      if ($urandom_range(1) == 1) send_store(hot + 16'(k), 16'($urandom_range(0, 1700)));
    steady_flow <= 1'b1;
    extra = 0;
    sent  = 0;
    while (extra < 6) begin
      window = (held_rtt != 16'd0) ? {16'd0, held_rtt} : {16'd0, cfg_default_rtt};
      if ($urandom_range(99) < 85)
        clock_ms += window + 32'd1 + $urandom_range(0, window);
      else
        clock_ms += $urandom_range(0, window);
      send_nack(hot, 16'($urandom), clock_ms);
      sent++;
      if (sent == 120) steady_flow <= 1'b0;
      if (slot_resends[hot_slot] == COUNT_MAX) extra++;
    end
    drain_answers();
  endtask

  // Sender-like traffic: runs of stores, NACKs for recent ids, good reports,
  // and some fully random requests. Several register settings.
  task automatic test_random_traffic();
    logic [15:0] next_seq;
    logic [15:0] mask;
    logic [31:0] window;
    logic [31:0] lsr;
    logic [31:0] dlsr;
    int unsigned roll;
    int unsigned count;
    next_seq = 16'($urandom);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       program_all(1'b1, 16'd1500, 16'($urandom_range(1, 300)));
        1:       program_all(1'b1, 16'hFFFF, 16'd1);
        2:       program_all(1'b0, 16'($urandom), 16'hFFFF);
        default: program_all(1'b1, 16'($urandom_range(64, 1500)), 16'($urandom_range(1, 65535)));
      endcase
      count = (phase == 2) ? 20 : 60;
      for (int n = 0; n < count; n++) begin
        roll = $urandom_range(99);
        if (roll < 40) begin
          if (roll < 2) next_seq += 16'(SLOTS);   // skips ahead by the table depth
          if ($urandom_range(9) == 0)
            send_store(next_seq, 16'($urandom));
          else
            send_store(next_seq, 16'($urandom_range(0, cfg_mtu)));
          next_seq++;
        end else if (roll < 75) begin
          window = (held_rtt != 16'd0) ? {16'd0, held_rtt} : {16'd0, cfg_default_rtt};
          clock_ms += $urandom_range(0, 2 * window + 2);
          mask = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom & $urandom & $urandom);
          send_nack(next_seq - 16'($urandom_range(1, 48)), mask, clock_ms);
        end else if (roll < 88) begin
          lsr  = $urandom | 32'd1;
          dlsr = $urandom_range(1, 131072);
          send_report(lsr, dlsr, lsr + dlsr + $urandom_range(0, 20000));
        end else begin
          issue_request(noisy_request(2'($urandom)));
        end
      end
      drain_answers();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_NACK_ENABLE;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    clock_ms     = $urandom;
    for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // the table sweep after reset holds ready low; the first request waits it out
    test_store_and_nack();
    test_rtt_reports();
    test_register_extremes();
    test_resend_saturation();
    test_random_traffic();
    repeat (40) @(posedge clk);   // anything extra shows up in the checker
    if (pending_answers.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_answers.size()));
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rtpnack_pkg.sv
design/rtpnack_req_if.sv
design/rtpnack_res_if.sv
design/rtpnack_table.sv
design/rtp_nack_retransmit_selector_top.sv
dv/rtp_nack_retransmit_selector_top_tb.sv
